>>> src/noc_pkg.sv
`timescale 1ns / 1ps

package noc_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned DIST_W     = 15;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned SQ_OP_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FWD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FWD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_SQ = 2'd3;

  localparam logic [DIST_W-1:0] MIN_FWD_RST = 15'd500;
  localparam logic [DIST_W-1:0] MAX_FWD_RST = 15'd3000;
  localparam logic [DIST_W-1:0] HALF_W_RST  = 15'd400;
  localparam logic [SQ_W-1:0]   CONE_SQ_RST = 32'd1000000;

  typedef struct packed {
    logic [DIST_W-1:0] min_fwd;
    logic [DIST_W-1:0] max_fwd;
    logic [DIST_W-1:0] half_w;
    logic [SQ_W-1:0]   cone_sq;
  } cfg_t;

endpackage

>>> src/noc_fifo.sv
`timescale 1ns / 1ps

module noc_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> src/noc_front.sv
`timescale 1ns / 1ps

module noc_front #(
  parameter int unsigned COORD_BITS = noc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  noc_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         last_point_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic                         ent_valid_o,
  output logic signed [COORD_BITS-1:0] ent_x_o,
  output logic signed [COORD_BITS-1:0] ent_y_o
);

  import noc_pkg::*;

  localparam int unsigned XW = ((COORD_BITS > DIST_W + 1) ? COORD_BITS : DIST_W + 1) + 1;

  logic signed [XW-1:0]         px_x, py_x, py_abs, min_x, max_x, half_x;
  logic                         in_win, take, accept;
  logic                         best_v_q, best_v_d, new_v;
  logic signed [COORD_BITS-1:0] best_x_q, best_x_d, best_y_q, best_y_d, new_x, new_y;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last_point_i;

  assign px_x   = XW'(point_x_i);
  assign py_x   = XW'(point_y_i);
  assign py_abs = py_x[XW-1] ? -py_x : py_x;
  assign min_x  = XW'(cfg_i.min_fwd);
  assign max_x  = XW'(cfg_i.max_fwd);
  assign half_x = XW'(cfg_i.half_w);

  assign in_win = (px_x >= min_x) && (px_x <= max_x) && (py_abs <= half_x);
  assign take   = in_win && (!best_v_q || (point_x_i < best_x_q));

  assign new_v = take || best_v_q;
  assign new_x = take ? point_x_i : best_x_q;
  assign new_y = take ? point_y_i : best_y_q;

  assign ent_valid_o = new_v;
  assign ent_x_o     = new_x;
  assign ent_y_o     = new_y;

  // The kept point is zero whenever nothing is kept, so the frame record needs no masking.
  always_comb begin
    best_v_d = best_v_q;
    best_x_d = best_x_q;
    best_y_d = best_y_q;
    if (accept) begin
      if (last_point_i) begin
        best_v_d = 1'b0;
        best_x_d = '0;
        best_y_d = '0;
      end else begin
        best_v_d = new_v;
        best_x_d = new_x;
        best_y_d = new_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_v_q <= 1'b0;
      best_x_q <= '0;
      best_y_q <= '0;
    end else begin
      best_v_q <= best_v_d;
      best_x_q <= best_x_d;
      best_y_q <= best_y_d;
    end
  end

endmodule

>>> src/noc_back.sv
`timescale 1ns / 1ps

module noc_back #(
  parameter int unsigned COORD_BITS = noc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  noc_pkg::cfg_t                cfg_i,
  input  logic                         ent_avail_i,
  output logic                         pop_o,
  input  logic                         ent_valid_i,
  input  logic signed [COORD_BITS-1:0] ent_x_i,
  input  logic signed [COORD_BITS-1:0] ent_y_i,
  input  logic                         ent_cone_i,
  input  logic signed [COORD_BITS-1:0] ent_cone_x_i,
  input  logic signed [COORD_BITS-1:0] ent_cone_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         obstacle_found_o,
  output logic signed [COORD_BITS-1:0] obstacle_x_o,
  output logic signed [COORD_BITS-1:0] obstacle_y_o,
  output logic                         cone_suppressed_o
);

  import noc_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned AW = (DW > SQ_OP_W + 1) ? DW : SQ_OP_W + 1;

  logic                         en;
  logic signed [DW-1:0]         dx, dy;
  logic [DW-1:0]                ax, ay;
  logic [AW-1:0]                ax_ext, ay_ext;
  logic                         far_d;

  logic                         s1_v_q, s1_bv_q, s1_cv_q, s1_far_q;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic [SQ_OP_W-1:0]           s1_ax_q, s1_ay_q;

  logic                         s2_v_q, s2_bv_q, s2_cv_q, s2_far_q;
  logic signed [COORD_BITS-1:0] s2_x_q, s2_y_q;
  logic [2*SQ_OP_W-1:0]         s2_sqx_q, s2_sqy_q;

  logic [SQ_W:0]                dist_sq;
  logic                         supp;

  logic                         out_v_q, found_q, supp_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en;

  assign dx     = DW'(ent_x_i) - DW'(ent_cone_x_i);
  assign dy     = DW'(ent_y_i) - DW'(ent_cone_y_i);
  assign ax     = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay     = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign ax_ext = AW'(ax);
  assign ay_ext = AW'(ay);
  assign far_d  = (ax_ext[AW-1:SQ_OP_W] != '0) || (ay_ext[AW-1:SQ_OP_W] != '0);

  assign dist_sq = (SQ_W + 1)'(s2_sqx_q) + (SQ_W + 1)'(s2_sqy_q);
  assign supp    = s2_bv_q && s2_cv_q && !s2_far_q && (dist_sq < (SQ_W + 1)'(cfg_i.cone_sq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= ent_avail_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bv_q  <= ent_valid_i;
      s1_cv_q  <= ent_cone_i;
      s1_far_q <= far_d;
      s1_x_q   <= ent_x_i;
      s1_y_q   <= ent_y_i;
      s1_ax_q  <= ax_ext[SQ_OP_W-1:0];
      s1_ay_q  <= ay_ext[SQ_OP_W-1:0];

      s2_bv_q  <= s1_bv_q;
      s2_cv_q  <= s1_cv_q;
      s2_far_q <= s1_far_q;
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
      s2_sqx_q <= s1_ax_q * s1_ax_q;
      s2_sqy_q <= s1_ay_q * s1_ay_q;

      found_q <= s2_bv_q && !supp;
      supp_q  <= supp;
      out_x_q <= s2_x_q;
      out_y_q <= s2_y_q;
    end
  end

  assign out_valid_o       = out_v_q;
  assign obstacle_found_o  = found_q;
  assign cone_suppressed_o = supp_q;
  assign obstacle_x_o      = out_x_q;
  assign obstacle_y_o      = out_y_q;

endmodule

>>> src/nearest_obstacle_in_corridor.sv
`timescale 1ns / 1ps

// Takes one point per cycle while input ready is high and keeps the nearest point inside the
// forward corridor; the point flagged last closes the frame and yields one result beat carrying
// the nearest point, whether it was found, and whether a valid cone within the exclusion radius
// suppressed it. The front section holds the running nearest point. A closed frame enters a
// two-entry queue, and the cone distance check runs as a three-stage pipeline (axis differences,
// squaring, sum and compare into the output register) that a result beat passes through after
// leaving the queue. Input ready drops only while the queue is full, which happens when results
// are not taken.
module nearest_obstacle_in_corridor #(
  parameter int unsigned COORD_BITS = noc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [noc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [noc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  input  logic                                last_point_i,
  input  logic                                cone_valid_i,
  input  logic signed [COORD_BITS-1:0]        cone_pos_x_i,
  input  logic signed [COORD_BITS-1:0]        cone_pos_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                obstacle_found_o,
  output logic signed [COORD_BITS-1:0]        obstacle_x_o,
  output logic signed [COORD_BITS-1:0]        obstacle_y_o,
  output logic                                cone_suppressed_o
);

  import noc_pkg::*;

  localparam int unsigned ENT_W = 4 * COORD_BITS + 2;

  cfg_t                         cfg_q;
  logic                         full, push, avail, pop;
  logic                         f_valid;
  logic signed [COORD_BITS-1:0] f_x, f_y;
  logic [ENT_W-1:0]             wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_fwd <= MIN_FWD_RST;
      cfg_q.max_fwd <= MAX_FWD_RST;
      cfg_q.half_w  <= HALF_W_RST;
      cfg_q.cone_sq <= CONE_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_FWD: cfg_q.min_fwd <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_FWD: cfg_q.max_fwd <= cfg_data_i[DIST_W-1:0];
        CFG_HALF_W:  cfg_q.half_w  <= cfg_data_i[DIST_W-1:0];
        CFG_CONE_SQ: cfg_q.cone_sq <= cfg_data_i[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  noc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .full_i       (full),
    .push_o       (push),
    .ent_valid_o  (f_valid),
    .ent_x_o      (f_x),
    .ent_y_o      (f_y)
  );

  assign wdata = {f_valid, f_x, f_y, cone_valid_i, cone_pos_x_i, cone_pos_y_i};

  noc_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (avail),
    .rdata_o (rdata)
  );

  noc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .ent_avail_i       (avail),
    .pop_o             (pop),
    .ent_valid_i       (rdata[ENT_W-1]),
    .ent_x_i           (rdata[ENT_W-2 -: COORD_BITS]),
    .ent_y_i           (rdata[ENT_W-2-COORD_BITS -: COORD_BITS]),
    .ent_cone_i        (rdata[2*COORD_BITS]),
    .ent_cone_x_i      (rdata[2*COORD_BITS-1 -: COORD_BITS]),
    .ent_cone_y_i      (rdata[COORD_BITS-1:0]),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .obstacle_found_o  (obstacle_found_o),
    .obstacle_x_o      (obstacle_x_o),
    .obstacle_y_o      (obstacle_y_o),
    .cone_suppressed_o (cone_suppressed_o)
  );

  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(obstacle_found_o && cone_suppressed_o))
    else $error("obstacle reported as both found and suppressed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !obstacle_found_o && !cone_suppressed_o) |->
      (obstacle_x_o == '0 && obstacle_y_o == '0))
    else $error("empty frame reported nonzero coordinates");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_point_i) |-> !full)
    else $error("frame closed while the queue was full");

endmodule
